@@ src/spr_pkg.sv @@
package spr_pkg;

    typedef logic [15:0] t_word;

    localparam t_word C_PERIOD_LOW  = 16'd100;
    localparam t_word C_PERIOD_HIGH = 16'hFFFF;

    localparam t_word C_BAND_TOP_MIN  = 16'd24000;
    localparam t_word C_BAND_HIGH_MIN = 16'd17000;
    localparam t_word C_BAND_MID_MIN  = 16'd13000;

    localparam t_word C_BAND_TOP_DIV  = 16'd10000;
    localparam t_word C_BAND_HIGH_DIV = 16'd1000;
    localparam t_word C_BAND_MID_DIV  = 16'd250;
    localparam t_word C_BAND_LOW_DIV  = 16'd100;

    localparam t_word C_BAND_HIGH_SCALE = 16'd10;
    localparam t_word C_BAND_MID_SCALE  = 16'd40;
    localparam t_word C_BAND_LOW_SCALE  = 16'd100;

    localparam t_word C_SPEED_DIV = 16'd100;
    localparam t_word C_SPEED_NUM = 16'd30000;
    localparam t_word C_THIRD     = 16'd3;
    localparam t_word C_SIXTH     = 16'd6;

    localparam t_word C_RST_ACCEL      = 16'd10;
    localparam t_word C_RST_MIN_PERIOD = 16'd1500;
    localparam t_word C_RST_END_PERIOD = 16'd2500;
    localparam t_word C_RST_PERIOD     = 16'd2500;

    localparam int DIV_WIDTH          = 16;
    localparam int DIV_BITS_PER_CYCLE = 4;
    localparam int DIV_CYCLES         = DIV_WIDTH / DIV_BITS_PER_CYCLE;
    localparam int DIV_CNT_W          = $clog2(DIV_CYCLES);

    localparam logic       OP_LOAD = 1'b0;
    localparam logic       OP_STEP = 1'b1;

    localparam logic [1:0] PH_HOLD  = 2'd0;
    localparam logic [1:0] PH_DECEL = 2'd1;
    localparam logic [1:0] PH_ACCEL = 2'd2;

    localparam logic [1:0] CFG_ACCEL      = 2'd0;
    localparam logic [1:0] CFG_MIN_PERIOD = 2'd1;
    localparam logic [1:0] CFG_END_PERIOD = 2'd2;

    typedef enum logic [1:0] {
        BAND_TOP,
        BAND_HIGH,
        BAND_MID,
        BAND_LOW
    } t_band;

    typedef enum logic [3:0] {
        S_IDLE,
        S_PF,
        S_MUL,
        S_SCALE,
        S_SPD_Q,
        S_SPD,
        S_CMP,
        S_X3,
        S_X6,
        S_XMUL,
        S_DIST,
        S_DECIDE,
        S_DONE
    } t_state;

    typedef struct packed {
        logic  start;
        t_word num;
        t_word den;
    } t_div_req;

    typedef struct packed {
        logic  busy;
        logic  done;
        t_word quot;
    } t_div_rsp;

    typedef struct packed {
        logic  start;
        logic  opcode;
        t_word start_period;
        t_word steps_left;
        t_word accel;
        t_word min_per;
        t_word end_per;
        logic  take;
    } t_seq_req;

    typedef struct packed {
        logic       busy;
        logic       done;
        t_word      period;
        logic [1:0] phase;
    } t_seq_rsp;

endpackage

@@ src/spr_div.sv @@
module spr_div
    import spr_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    t_word                r_rem;
    t_word                r_quo;
    t_word                r_den;

    t_word                n_rem;
    t_word                n_quo;
    logic [16:0]          v_trial;

    // restoring division, several quotient bits per cycle
    always_comb begin
        n_rem   = r_rem;
        n_quo   = r_quo;
        v_trial = '0;
        for (int k = 0; k < DIV_BITS_PER_CYCLE; k++) begin
            v_trial = {n_rem, n_quo[15]};
            if (v_trial >= {1'b0, r_den}) begin
                n_rem = 16'(v_trial - {1'b0, r_den});
                n_quo = {n_quo[14:0], 1'b1};
            end else begin
                n_rem = v_trial[15:0];
                n_quo = {n_quo[14:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == DIV_CNT_W'(DIV_CYCLES - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= '0;
            r_quo <= i_req.num;
            r_den <= i_req.den;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_quo <= n_quo;
        end
    end

    assign o_rsp.busy = r_busy;
    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_quo;

endmodule

@@ src/spr_seq.sv @@
module spr_seq
    import spr_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_seq_req i_req,
    output t_seq_rsp o_rsp,
    output t_div_req o_div,
    input  t_div_rsp i_div
);

    localparam logic [1:0] SEL_CUR = 2'd0;
    localparam logic [1:0] SEL_END = 2'd1;
    localparam logic [1:0] SEL_MIN = 2'd2;
    localparam logic [1:0] MUL_LAST = 2'd2;

    function automatic t_band f_band(input t_word p);
        if (p > C_BAND_TOP_MIN) begin
            return BAND_TOP;
        end else if (p > C_BAND_HIGH_MIN) begin
            return BAND_HIGH;
        end else if (p > C_BAND_MID_MIN) begin
            return BAND_MID;
        end
        return BAND_LOW;
    endfunction

    function automatic t_word f_band_div(input t_band b);
        t_word v;
        unique case (b)
            BAND_TOP:  v = C_BAND_TOP_DIV;
            BAND_HIGH: v = C_BAND_HIGH_DIV;
            BAND_MID:  v = C_BAND_MID_DIV;
            default:   v = C_BAND_LOW_DIV;
        endcase
        return v;
    endfunction

    function automatic t_word f_band_scale(input t_band b);
        t_word v;
        unique case (b)
            BAND_HIGH: v = C_BAND_HIGH_SCALE;
            BAND_MID:  v = C_BAND_MID_SCALE;
            default:   v = C_BAND_LOW_SCALE;
        endcase
        return v;
    endfunction

    function automatic t_word f_nz(input t_word v);
        return (v == '0) ? 16'd1 : v;
    endfunction

    t_state     r_state, n_state;
    t_word      r_p, n_p;
    logic [1:0] r_phase, n_phase;
    t_band      r_band, n_band;
    logic [1:0] r_cnt, n_cnt;
    logic [1:0] r_sel, n_sel;
    logic       r_xsel, n_xsel;
    t_word      r_steps, n_steps;
    t_word      r_pf, n_pf;
    t_word      r_d, n_d;
    t_word      r_q, n_q;
    t_word      r_cs, n_cs;
    t_word      r_es, n_es;
    t_word      r_ms, n_ms;
    t_word      r_t3, n_t3;
    t_word      r_t6, n_t6;
    t_word      r_a, n_a;
    t_word      r_b, n_b;
    t_word      r_dist, n_dist;

    t_word       mul_a;
    t_word       mul_b;
    logic [31:0] mul_full;
    t_word       mul_lo;
    logic        div_go;
    t_word       sel_period;
    logic [16:0] grow_sum;
    t_word       grow_p;
    t_word       shrink_p;

    assign mul_full = {16'b0, mul_a} * {16'b0, mul_b};
    assign mul_lo   = mul_full[15:0];
    assign div_go   = ~i_div.busy & ~i_div.done;

    always_comb begin
        case (r_sel)
            SEL_CUR: sel_period = r_p;
            SEL_END: sel_period = i_req.end_per;
            default: sel_period = i_req.min_per;
        endcase
    end

    assign grow_sum = {1'b0, r_p} + {1'b0, r_d};
    assign grow_p   = grow_sum[16] ? C_PERIOD_HIGH : grow_sum[15:0];
    assign shrink_p = (({1'b0, r_d} + {1'b0, C_PERIOD_LOW}) > {1'b0, r_p}) ?
                      C_PERIOD_LOW : 16'(r_p - r_d);

    always_comb begin
        n_state = r_state;
        n_p     = r_p;
        n_phase = r_phase;
        n_band  = r_band;
        n_cnt   = r_cnt;
        n_sel   = r_sel;
        n_xsel  = r_xsel;
        n_steps = r_steps;
        n_pf    = r_pf;
        n_d     = r_d;
        n_q     = r_q;
        n_cs    = r_cs;
        n_es    = r_es;
        n_ms    = r_ms;
        n_t3    = r_t3;
        n_t6    = r_t6;
        n_a     = r_a;
        n_b     = r_b;
        n_dist  = r_dist;
        mul_a   = r_d;
        mul_b   = r_pf;
        o_div.start = 1'b0;
        o_div.num   = r_p;
        o_div.den   = C_SPEED_DIV;

        unique case (r_state)
            S_IDLE: begin
                if (i_req.start) begin
                    n_steps = i_req.steps_left;
                    n_phase = PH_HOLD;
                    if (i_req.opcode == OP_LOAD) begin
                        n_p     = (i_req.start_period < C_PERIOD_LOW) ?
                                  C_PERIOD_LOW : i_req.start_period;
                        n_state = S_DONE;
                    end else if (i_req.accel == '0) begin
                        n_state = S_DONE;
                    end else begin
                        n_band  = f_band(r_p);
                        n_d     = i_req.accel;
                        n_cnt   = '0;
                        n_state = S_PF;
                    end
                end
            end
            S_PF: begin
                o_div.start = div_go;
                o_div.num   = r_p;
                o_div.den   = f_band_div(r_band);
                if (i_div.done) begin
                    n_pf    = i_div.quot;
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                mul_a = r_d;
                mul_b = r_pf;
                if (r_band == BAND_TOP) begin
                    if (r_cnt == MUL_LAST) begin
                        n_d     = f_nz(mul_lo);
                        n_sel   = SEL_CUR;
                        n_state = S_SPD_Q;
                    end else begin
                        n_d   = mul_lo;
                        n_cnt = r_cnt + 1'b1;
                    end
                end else begin
                    n_d     = mul_lo;
                    n_state = S_SCALE;
                end
            end
            S_SCALE: begin
                o_div.start = div_go;
                o_div.num   = r_d;
                o_div.den   = f_band_scale(r_band);
                if (i_div.done) begin
                    if (r_cnt == MUL_LAST) begin
                        n_d     = f_nz(i_div.quot);
                        n_sel   = SEL_CUR;
                        n_state = S_SPD_Q;
                    end else begin
                        n_d     = i_div.quot;
                        n_cnt   = r_cnt + 1'b1;
                        n_state = S_MUL;
                    end
                end
            end
            S_SPD_Q: begin
                o_div.start = div_go;
                o_div.num   = sel_period;
                o_div.den   = C_SPEED_DIV;
                if (i_div.done) begin
                    n_q     = f_nz(i_div.quot);
                    n_state = S_SPD;
                end
            end
            S_SPD: begin
                o_div.start = div_go;
                o_div.num   = C_SPEED_NUM;
                o_div.den   = r_q;
                if (i_div.done) begin
                    case (r_sel)
                        SEL_CUR: n_cs = i_div.quot;
                        SEL_END: n_es = i_div.quot;
                        default: n_ms = i_div.quot;
                    endcase
                    if (r_sel == SEL_MIN) begin
                        n_state = S_CMP;
                    end else begin
                        n_sel   = r_sel + 1'b1;
                        n_state = S_SPD_Q;
                    end
                end
            end
            S_CMP: begin
                if (r_cs > r_es) begin
                    n_xsel  = 1'b0;
                    n_state = S_X3;
                end else begin
                    n_dist  = '0;
                    n_state = S_DECIDE;
                end
            end
            S_X3: begin
                o_div.start = div_go;
                o_div.num   = r_xsel ? r_es : r_cs;
                o_div.den   = C_THIRD;
                if (i_div.done) begin
                    n_t3    = i_div.quot;
                    n_state = S_X6;
                end
            end
            S_X6: begin
                o_div.start = div_go;
                o_div.num   = r_xsel ? r_es : r_cs;
                o_div.den   = C_SIXTH;
                if (i_div.done) begin
                    n_t6    = i_div.quot;
                    n_state = S_XMUL;
                end
            end
            S_XMUL: begin
                mul_a = r_t3;
                mul_b = r_t6;
                if (!r_xsel) begin
                    n_a     = mul_lo;
                    n_xsel  = 1'b1;
                    n_state = S_X3;
                end else begin
                    n_b     = mul_lo;
                    n_state = S_DIST;
                end
            end
            S_DIST: begin
                o_div.start = div_go;
                o_div.num   = 16'(r_a - r_b);
                o_div.den   = i_req.accel;
                if (i_div.done) begin
                    n_dist  = i_div.quot;
                    n_state = S_DECIDE;
                end
            end
            S_DECIDE: begin
                if (r_dist >= r_steps) begin
                    n_p     = grow_p;
                    n_phase = PH_DECEL;
                end else if (r_cs < r_ms) begin
                    n_p     = shrink_p;
                    n_phase = PH_ACCEL;
                end else begin
                    n_phase = PH_HOLD;
                end
                n_state = S_DONE;
            end
            S_DONE: begin
                if (i_req.take) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_p     <= C_RST_PERIOD;
        end else begin
            r_state <= n_state;
            r_p     <= n_p;
        end
    end

    always_ff @(posedge i_clk) begin
        r_phase <= n_phase;
        r_band  <= n_band;
        r_cnt   <= n_cnt;
        r_sel   <= n_sel;
        r_xsel  <= n_xsel;
        r_steps <= n_steps;
        r_pf    <= n_pf;
        r_d     <= n_d;
        r_q     <= n_q;
        r_cs    <= n_cs;
        r_es    <= n_es;
        r_ms    <= n_ms;
        r_t3    <= n_t3;
        r_t6    <= n_t6;
        r_a     <= n_a;
        r_b     <= n_b;
        r_dist  <= n_dist;
    end

    assign o_rsp.busy   = (r_state != S_IDLE);
    assign o_rsp.done   = (r_state == S_DONE);
    assign o_rsp.period = r_p;
    assign o_rsp.phase  = r_phase;

endmodule

@@ src/step_period_ramp_core.sv @@
// channel | direction | valid       | stall       | word
// in      | input     | i_in_valid  | o_in_stall  | i_opcode, i_start_period, i_steps_to_end
// out     | output    | o_out_valid | i_out_stall | o_period, o_phase
// cfg     | input     | i_cfg_wr_en | none        | i_cfg_index, i_cfg_data
//
// Load words and step words with accel zero skip the divider; a step word makes up to
// 15 passes through the shared 4-bit-per-cycle divider.
// One word is in flight at a time; the next is taken while the result waits at the output.
// Synchronous active-low reset sets the period to 2500 and the config registers to their defaults.
// A stalled output holds its word; the core waits until the output register is free.
module step_period_ramp_core
    import spr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_opcode,
    input  logic [15:0] i_start_period,
    input  logic [15:0] i_steps_to_end,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [15:0] o_period,
    output logic [1:0]  o_phase,
    input  logic        i_cfg_wr_en,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    t_word      r_accel;
    t_word      r_min_period;
    t_word      r_end_period;
    logic       r_out_valid;
    t_word      r_out_period;
    logic [1:0] r_out_phase;

    t_seq_req   seq_req;
    t_seq_rsp   seq_rsp;
    t_div_req   div_req;
    t_div_rsp   div_rsp;
    logic       out_free;

    assign out_free = ~r_out_valid | ~i_out_stall;

    assign seq_req.start        = i_in_valid & ~seq_rsp.busy;
    assign seq_req.opcode       = i_opcode;
    assign seq_req.start_period = i_start_period;
    assign seq_req.steps_left   = i_steps_to_end;
    assign seq_req.accel        = r_accel;
    assign seq_req.min_per      = r_min_period;
    assign seq_req.end_per      = r_end_period;
    assign seq_req.take         = out_free;

    spr_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (seq_req),
        .o_rsp   (seq_rsp),
        .o_div   (div_req),
        .i_div   (div_rsp)
    );

    spr_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_accel      <= C_RST_ACCEL;
            r_min_period <= C_RST_MIN_PERIOD;
            r_end_period <= C_RST_END_PERIOD;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                CFG_ACCEL:      r_accel      <= i_cfg_data;
                CFG_MIN_PERIOD: r_min_period <= i_cfg_data;
                CFG_END_PERIOD: r_end_period <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (seq_rsp.done && out_free) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (seq_rsp.done && out_free) begin
            r_out_period <= seq_rsp.period;
            r_out_phase  <= seq_rsp.phase;
        end
    end

    assign o_in_stall  = seq_rsp.busy;
    assign o_out_valid = r_out_valid;
    assign o_period    = r_out_period;
    assign o_phase     = r_out_phase;

endmodule

@@ src/spr_chk.sv @@
module spr_chk
    import spr_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_stall,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [15:0] o_period,
    input logic [1:0]  o_phase
);

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("core took a second word without going busy");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=>
        (o_out_valid && $stable(o_period) && $stable(o_phase)))
        else $error("stalled output word changed");

    a_period_floor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_period >= C_PERIOD_LOW))
        else $error("output period below floor");

    a_phase_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_phase == PH_HOLD || o_phase == PH_DECEL ||
                         o_phase == PH_ACCEL))
        else $error("output phase code out of range");

endmodule

bind step_period_ramp_core spr_chk u_spr_chk (.*);
